@@ rtl/core/stepper_step_time_generator_assert.svh @@
// Assertion macros for the stepper step time generator.
// Used by the top level, which checks its own logic; needs clk and rst in scope.
`ifndef STEPPER_STEP_TIME_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_TIME_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SSTG_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sstg assertion failed");
`define SSTG_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstg implication failed");
`else
`define SSTG_ASSERT(lbl, cond)
`define SSTG_IMPLY(lbl, ante, cons)
`endif
`endif

@@ rtl/core/sstg_pkg.sv @@
// Package of the stepper step time generator: constants, register indexes and types.
// Has no dependencies; the interfaces, the top level, sstg_muldiv and the testbench use it.
package sstg_pkg;

  localparam int MAX_STEPS = 64;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  localparam int POS_W  = 32;
  localparam int STEP_W = 31;
  localparam int PER_W  = 16;
  localparam int SEG_W  = 16;
  localparam int TIME_W = 32;
  localparam int MAG_W  = POS_W + 1;
  localparam int PROD_W = MAG_W + PER_W;
  localparam int IDX_W  = 8;

  localparam logic [IDX_W-1:0] CFG_STEP_SIZE = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_PERIOD    = IDX_W'(1);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [PER_W-1:0]  PER_RESET  = PER_W'(1000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_FIN,
    ST_PUSH
  } sstg_state_t;

  typedef struct packed {
    logic [PROD_W-1:0] quotient;
    logic              rem_nz;
    logic [TIME_W-1:0] seg_ticks;
  } sstg_md_res_t;

endpackage

@@ rtl/core/sstg_if.sv @@
// Handshake interfaces of the stepper step time generator: input, result and config.
// Depends on sstg_pkg for field widths.
interface sstg_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sstg_pkg::POS_W-1:0] sample_position;
  logic                             first_sample;
  modport source (output valid, sample_position, first_sample, input ready);
  modport sink (input valid, sample_position, first_sample, output ready);
endinterface

interface sstg_out_if;
  logic                              valid;
  logic                              ready;
  logic [sstg_pkg::TIME_W-1:0]       step_time;
  logic                              direction;
  logic signed [sstg_pkg::POS_W-1:0] step_position;
  logic                              last_of_run;
  logic                              overrun;
  modport source (output valid, step_time, direction, step_position, last_of_run, overrun,
                  input ready);
  modport sink (input valid, step_time, direction, step_position, last_of_run, overrun,
                output ready);
endinterface

interface sstg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sstg_pkg::IDX_W-1:0]  index;
  logic [31:0]                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/stepper_step_time_generator.sv @@
// Top level of the stepper step time generator: sequencer, state and result register.
// Depends on sstg_pkg, the sstg interfaces, sstg_muldiv and the assertion header.
//
//   channel   direction  carries
//   in_ch     sink       sample_position, first_sample
//   out_ch    source     step_time, direction, step_position, last_of_run, overrun
//   cfg_ch    sink       index, data (step length, period_ticks)
//
// A first sample is taken in idle and sets the origin; a sample that takes no step is only checked.
// Otherwise each step is checked, computed by the serial multiply and divide in sstg_muldiv,
// finished into a hold register and pushed out before the next step is computed.
// Up to 64 steps per sample; when more are due, the last one is marked as overrun.
// Reset restores the register defaults and clears position state; no clearing pass.
// A stalled output holds the sequencer only when a second result is ready to go.
`include "stepper_step_time_generator_assert.svh"
module stepper_step_time_generator (
  input logic    clk,
  input logic    rst,
  sstg_in_if.sink   in_ch,
  sstg_out_if.source out_ch,
  sstg_cfg_if.sink  cfg_ch
);
  import sstg_pkg::*;

  sstg_state_t state, state_next;

  logic [STEP_W-1:0]       step_len;
  logic [PER_W-1:0]        period_ticks;
  logic [POS_W-1:0]        origin;
  logic [POS_W-1:0]        previous;
  logic [POS_W-1:0]        stepper;
  logic [SEG_W-1:0]        seg;
  logic [POS_W-1:0]        sample_q;
  logic signed [POS_W-1:0] target_rel;
  logic signed [POS_W-1:0] prev_rel;
  logic signed [MAG_W-1:0] diff;
  logic [CNT_W-1:0]        count;
  logic                    have_hold;
  logic                    push_end;
  logic                    neg;
  logic [TIME_W-1:0]       hold_time;
  logic [POS_W-1:0]        hold_pos;
  logic                    hold_last;
  logic                    hold_ovf;
  logic                    out_valid;

  logic                    in_fire;
  logic                    push_ok;
  logic                    fwd;
  logic                    qual;
  logic                    at_max;
  logic                    md_start;
  logic                    md_done;
  sstg_md_res_t            md_res;
  logic signed [POS_W-1:0] tgt_c;
  logic signed [POS_W-1:0] prv_c;
  logic signed [MAG_W-1:0] diff_c;
  logic signed [POS_W+1:0] next_c;
  logic signed [POS_W+1:0] tgt_x;
  logic signed [MAG_W-1:0] m_c;
  logic [MAG_W-1:0]        m_mag;
  logic [MAG_W-1:0]        d_mag;
  logic signed [TIME_W+18:0] t_c;
  logic [TIME_W-1:0]       t_sat;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign push_ok = !out_valid || out_ch.ready;

  assign tgt_c  = in_ch.sample_position - origin;
  assign prv_c  = previous - origin;
  assign diff_c = MAG_W'(tgt_c) - MAG_W'(prv_c);

  assign fwd    = !diff[MAG_W-1] && (diff != '0);
  assign tgt_x  = (POS_W + 2)'(target_rel);
  assign next_c = fwd ? (POS_W + 2)'($signed(stepper)) + $signed({3'b000, step_len})
                      : (POS_W + 2)'($signed(stepper)) - $signed({3'b000, step_len});
  assign qual   = (diff != '0) && (fwd ? (next_c < tgt_x) : (next_c > tgt_x));
  assign at_max = count == CNT_W'(MAX_STEPS);
  assign m_c    = MAG_W'($signed(next_c[POS_W-1:0])) - MAG_W'(prev_rel);
  assign m_mag  = m_c[MAG_W-1] ? MAG_W'(-m_c) : m_c;
  assign d_mag  = diff[MAG_W-1] ? MAG_W'(-diff) : diff;

  assign t_c = neg ? $signed({19'd0, md_res.seg_ticks}) - $signed({2'b00, md_res.quotient})
                     - $signed({50'd0, md_res.rem_nz})
                   : $signed({19'd0, md_res.seg_ticks}) + $signed({2'b00, md_res.quotient});
  assign t_sat = t_c[TIME_W+18] ? '0 : ((|t_c[TIME_W+17:TIME_W]) ? '1 : t_c[TIME_W-1:0]);

  sstg_muldiv u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .per     (period_ticks),
    .seg     (seg),
    .mag     (m_mag),
    .divisor (d_mag),
    .done    (md_done),
    .res     (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    md_start    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && !in_ch.first_sample) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (!qual) begin
          state_next = have_hold ? ST_PUSH : ST_IDLE;
        end else if (at_max || have_hold) begin
          state_next = ST_PUSH;
        end else begin
          md_start   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (md_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_CHECK;
      end
      ST_PUSH: begin
        if (push_ok) begin
          state_next = push_end ? ST_IDLE : ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_len     <= STEP_RESET;
      period_ticks <= PER_RESET;
      origin       <= '0;
      previous     <= '0;
      stepper      <= '0;
      seg          <= '0;
      count        <= '0;
      have_hold    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_STEP_SIZE) begin
          step_len <= cfg_ch.data[STEP_W-1:0];
        end else if (cfg_ch.index == CFG_PERIOD) begin
          period_ticks <= cfg_ch.data[PER_W-1:0];
        end
      end
      if (out_ch.valid && out_ch.ready && !(state == ST_PUSH && push_ok)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.first_sample) begin
              origin   <= in_ch.sample_position;
              previous <= in_ch.sample_position;
              stepper  <= '0;
              seg      <= '0;
            end else begin
              sample_q   <= in_ch.sample_position;
              target_rel <= tgt_c;
              prev_rel   <= prv_c;
              diff       <= diff_c;
              count      <= '0;
            end
          end
        end
        ST_CHECK: begin
          priority if (!qual) begin
            if (have_hold) begin
              hold_last <= 1'b1;
              push_end  <= 1'b1;
            end else begin
              previous <= sample_q;
              seg      <= (seg == '1) ? seg : seg + SEG_W'(1);
            end
          end else if (at_max) begin
            hold_last <= 1'b1;
            hold_ovf  <= 1'b1;
            push_end  <= 1'b1;
          end else if (have_hold) begin
            push_end <= 1'b0;
          end else begin
            stepper <= next_c[POS_W-1:0];
            neg     <= m_c[MAG_W-1] ^ diff[MAG_W-1];
          end
        end
        ST_CALC: begin
        end
        ST_FIN: begin
          hold_time <= t_sat;
          hold_pos  <= stepper;
          hold_last <= 1'b0;
          hold_ovf  <= 1'b0;
          have_hold <= 1'b1;
          count     <= count + CNT_W'(1);
        end
        ST_PUSH: begin
          if (push_ok) begin
            out_valid            <= 1'b1;
            out_ch.step_time     <= hold_time;
            out_ch.direction     <= fwd;
            out_ch.step_position <= hold_pos;
            out_ch.last_of_run   <= hold_last;
            out_ch.overrun       <= hold_ovf;
            have_hold            <= 1'b0;
            if (push_end) begin
              previous <= sample_q;
              seg      <= (seg == '1) ? seg : seg + SEG_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  `SSTG_ASSERT(a_count_limit, count <= CNT_W'(MAX_STEPS))
  `SSTG_IMPLY(a_done_in_calc, md_done, state == ST_CALC)
  `SSTG_IMPLY(a_result_from_push, $rose(out_valid), $past(state) == ST_PUSH)
  `SSTG_IMPLY(a_idle_no_hold, state == ST_IDLE, !have_hold)

endmodule

@@ rtl/core/sstg_muldiv.sv @@
// Bit-serial multiply and restoring divide for the step instant.
// Depends on sstg_pkg; multiplies over the 16 bits of per, then one quotient bit per cycle.
module sstg_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sstg_pkg::PER_W-1:0]  per,
  input  logic [sstg_pkg::SEG_W-1:0]  seg,
  input  logic [sstg_pkg::MAG_W-1:0]  mag,
  input  logic [sstg_pkg::MAG_W-1:0]  divisor,
  output logic                        done,
  output sstg_pkg::sstg_md_res_t      res
);
  import sstg_pkg::*;

  localparam int CYC_W = $clog2(PROD_W + 1);

  logic              busy;
  logic              dividing;
  logic [CYC_W-1:0]  cyc;
  logic [PER_W-1:0]  per_sh;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;
  logic [TIME_W-1:0] seg_sh;
  logic [TIME_W-1:0] pacc;
  logic [MAG_W-1:0]  rem;
  logic [MAG_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem, acc[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      dividing <= 1'b0;
      done     <= 1'b0;
      cyc      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dividing <= 1'b0;
        cyc      <= '0;
        per_sh   <= per;
        mcand    <= PROD_W'(mag);
        seg_sh   <= TIME_W'(seg);
        acc      <= '0;
        pacc     <= '0;
        rem      <= '0;
      end else if (busy && !dividing) begin
        if (per_sh[0]) begin
          acc  <= acc + mcand;
          pacc <= pacc + seg_sh;
        end
        per_sh <= per_sh >> 1;
        mcand  <= mcand << 1;
        seg_sh <= seg_sh << 1;
        if (cyc == CYC_W'(PER_W - 1)) begin
          dividing <= 1'b1;
          cyc      <= '0;
        end else begin
          cyc <= cyc + CYC_W'(1);
        end
      end else if (busy) begin
        acc <= {acc[PROD_W-2:0], ge};
        rem <= ge ? MAG_W'(rem_sh - {1'b0, divisor}) : rem_sh[MAG_W-1:0];
        if (cyc == CYC_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cyc <= cyc + CYC_W'(1);
        end
      end
    end
  end

  assign res.quotient  = acc;
  assign res.rem_nz    = |rem;
  assign res.seg_ticks = pacc;

endmodule

@@ tb/stepper_step_time_generator_tb.sv @@
// Testbench of the stepper step time generator: drives samples and register writes,
// predicts step times and checks every result item. Needs sstg_pkg and the sstg interfaces.
module stepper_step_time_generator_tb;
  import sstg_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]       step_time;
    logic                    direction;
    logic signed [POS_W-1:0] step_position;
    logic                    last_of_run;
    logic                    overrun;
  } step_rec_t;

  logic clk;
  logic rst;
  int   failures;
  int   hold_off;
  bit   stall_req;

  sstg_in_if  in_ch ();
  sstg_out_if out_ch ();
  sstg_cfg_if cfg_ch ();

  stepper_step_time_generator DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [30:0] pred_step;
  logic [15:0] pred_period;
  logic [31:0] pred_origin;
  logic [31:0] pred_prev;
  logic [31:0] pred_stepper;
  logic [15:0] pred_segment;
  step_rec_t   pending_steps[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  task automatic predict_steps(input logic [31:0] sample, input logic first);
    longint    target_rel;
    longint    prev_rel;
    longint    diff;
    longint    stepper;
    longint    nxt;
    longint    t;
    int        count;
    bit        fwd;
    step_rec_t rec;
    count = 0;
    if (first) begin
      pred_origin  = sample;
      pred_prev    = sample;
      pred_stepper = '0;
      pred_segment = '0;
      return;
    end
    target_rel = longint'($signed(sample - pred_origin));
    prev_rel   = longint'($signed(pred_prev - pred_origin));
    diff       = target_rel - prev_rel;
    fwd        = diff > 0;
    stepper    = longint'($signed(pred_stepper));
    if (diff != 0) begin
      forever begin
        nxt = fwd ? stepper + longint'(pred_step) : stepper - longint'(pred_step);
        if (fwd ? !(nxt < target_rel) : !(nxt > target_rel)) break;
        if (count >= MAX_STEPS) begin
          pending_steps[$].overrun = 1'b1;
          break;
        end
        t = longint'(pred_period) * longint'(pred_segment)
          + floor_quot(longint'(pred_period) * (nxt - prev_rel), diff);
        if (t < 0) t = 0;
        else if (t > 64'sh0FFFF_FFFF) t = 64'sh0FFFF_FFFF;
        stepper            = nxt;
        pred_stepper       = nxt[31:0];
        rec.step_time      = t[31:0];
        rec.direction      = fwd;
        rec.step_position  = nxt[31:0];
        rec.last_of_run    = 1'b0;
        rec.overrun        = 1'b0;
        pending_steps.push_back(rec);
        count++;
      end
    end
    if (count > 0) pending_steps[$].last_of_run = 1'b1;
    pred_prev = sample;
    if (pred_segment != 16'hFFFF) pred_segment++;
  endtask

  function automatic int gap_cycles();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic send_sample(input logic [31:0] sample, input logic first);
    int n;
    n = gap_cycles();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample_position <= sample;
    in_ch.first_sample    <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_steps(sample, first);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_STEP_SIZE) pred_step = value[30:0];
    else if (idx == CFG_PERIOD) pred_period = value[15:0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result item: step_time %0d", out_ch.step_time);
        failures++;
      end else begin
        step_rec_t e;
        e = pending_steps.pop_front();
        if (out_ch.step_time !== e.step_time) begin
          $error("step_time: expected %0d, actual %0d", e.step_time, out_ch.step_time);
          failures++;
        end
        if (out_ch.direction !== e.direction) begin
          $error("direction: expected %0d, actual %0d", e.direction, out_ch.direction);
          failures++;
        end
        if (out_ch.step_position !== e.step_position) begin
          $error("step_position: expected %0d, actual %0d", e.step_position,
                 out_ch.step_position);
          failures++;
        end
        if (out_ch.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d", e.last_of_run, out_ch.last_of_run);
          failures++;
        end
        if (out_ch.overrun !== e.overrun) begin
          $error("overrun: expected %0d, actual %0d", e.overrun, out_ch.overrun);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_req) begin
      stall_req = 1'b0;
      hold_off     <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off     <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 40) == 0) begin
      hold_off     <= $urandom_range(10, 60);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(0, 3) != 0;
    end
  end

  task automatic test_directed();
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0003_8000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0040_0000, 1'b0);
    send_sample(32'h0040_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8002_8000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'hFFFC_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    drain();
  endtask

  task automatic test_registers();
    write_reg(CFG_STEP_SIZE, 32'd1);
    write_reg(CFG_PERIOD, 32'd65535);
    send_sample(32'h1234_0000, 1'b1);
    send_sample(32'h1234_0030, 1'b0);
    send_sample(32'h1234_0010, 1'b0);
    drain();
    write_reg(CFG_STEP_SIZE, 32'h7FFF_FFFF);
    write_reg(CFG_PERIOD, 32'd1);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    drain();
    write_reg(CFG_STEP_SIZE, 32'h0000_4000);
    write_reg(CFG_PERIOD, 32'd1000);
    drain();
  endtask

  task automatic test_backpressure();
    send_sample(32'h0000_0000, 1'b1);
    stall_req = 1'b1;
    send_sample(32'h0004_0000, 1'b0);
    send_sample(32'h0008_0000, 1'b0);
    send_sample(32'h000C_0000, 1'b0);
    drain();
  endtask

  task automatic test_random(input int items);
    logic [31:0] pos;
    int          left;
    pos  = $urandom;
    left = items;
    while (left > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(CFG_STEP_SIZE, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 32'h8000));
        write_reg(CFG_PERIOD, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 2000));
      end
      pos = $urandom;
      send_sample(pos, 1'b1);
      left--;
      repeat ($urandom_range(3, 12)) begin
        if ($urandom_range(0, 9) == 0) pos = $urandom;
        else pos = pos + 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
        send_sample(pos, $urandom_range(0, 30) == 0);
        left--;
      end
    end
    drain();
  endtask

  initial begin
    failures = 0;
    hold_off = 0;
    stall_req = 1'b0;
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.sample_position <= '0;
    in_ch.first_sample <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    pred_step    = STEP_RESET;
    pred_period  = PER_RESET;
    pred_origin  = '0;
    pred_prev    = '0;
    pred_stepper = '0;
    pred_segment = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random(120);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #150000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
